@@ hw/rtl/wsp_pkg.sv @@
// Package for the WAV stream parser: parse phases, chunk tags, status codes
// and the result record. No dependencies.
`timescale 1ns / 1ps
package wsp_pkg;

    localparam logic [2:0] PH_RIFF  = 3'd0;
    localparam logic [2:0] PH_CHUNK = 3'd1;
    localparam logic [2:0] PH_FMT   = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_SKIP  = 3'd4;
    localparam logic [2:0] PH_PAD   = 3'd5;
    localparam logic [2:0] PH_FAIL  = 3'd6;

    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_FMT  = 32'h666D7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_HDR   = 3'd1;
    localparam logic [2:0] ST_NO_FMT    = 3'd2;
    localparam logic [2:0] ST_NO_DATA   = 3'd3;
    localparam logic [2:0] ST_BAD_DEPTH = 3'd4;

    localparam logic [15:0] FMT_FLOAT = 16'd3;

    typedef struct packed {
        logic        kind;
        logic [31:0] frame_count;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [2:0]  status;
        logic [31:0] right_sample;
        logic [31:0] left_sample;
    } result_t;

endpackage

@@ hw/rtl/wav_stream_parser_top.sv @@
// Top level of the WAV stream parser: byte-wise RIFF/WAVE walker, sample
// conversion to Q1.31 and a four-entry result queue. Depends on wsp_pkg.
`timescale 1ns / 1ps
// The parser takes up to one file byte per item and can accept an item in every
// cycle that s_tready is high: each byte updates the parse state in a single
// registered step, and the frame or status it causes is written straight into
// a four-entry result queue. s_tready drops only when fewer than two queue
// entries are free, so the input stalls only while the result side holds
// back. A result is queued as its item is accepted. An item with tlast set
// ends the file: one status result (tuser high) follows any frame of that
// item and the parser returns to its reset state for the next file.
module wav_stream_parser_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tuser,   // has_byte
    input  logic         s_tlast,   // end_of_file
    output logic         m_tvalid,
    input  logic         m_tready,
    // left_sample[31:0], right_sample[63:32], status[66:64], sample_rate[98:67],
    // channel_count[114:99], frame_count[146:115], zero fill [151:147]
    output logic [151:0] m_tdata,
    output logic         m_tuser    // kind
);

    logic [2:0]  phase_reg, phase_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic        hdr_ok_reg, hdr_ok_next;
    logic [15:0] fcode_reg, fcode_next;
    logic [15:0] chans_reg, chans_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic        fmt_seen_reg, fmt_seen_next;
    logic [31:0] data_seen_reg, data_seen_next;
    logic [31:0] gather_reg, gather_next;
    logic [12:0] pos_reg, pos_next;
    logic [15:0] sidx_reg, sidx_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] right_reg, right_next;
    logic [31:0] frames_reg, frames_next;

    wsp_pkg::result_t queue_mem [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] fill_reg;

    logic        take;
    logic        frame_we, status_we;
    wsp_pkg::result_t frame_res, status_res;
    logic [31:0] cnt_inc;
    logic [12:0] bps;
    logic [15:0] ch_eff;
    logic [31:0] gval, conv;

    assign take = s_tvalid && s_tready;
    assign s_tready = (fill_reg <= 3'd2);
    assign cnt_inc = cnt_reg + 32'd1;
    assign bps = bits_reg[15:3];
    assign ch_eff = (chans_reg == 16'd0) ? 16'd1 : chans_reg;

    // Float to Q1.31: scale by 2^31, truncate toward zero, saturate
    function automatic logic [31:0] float_q31(input logic [31:0] u);
        logic [7:0]  e;
        logic [23:0] m;
        logic signed [9:0] sh;
        logic [31:0] mag;
        logic [9:0]  rsh;
        e = u[30:23];
        m = (e != 8'd0) ? {1'b1, u[22:0]} : {1'b0, u[22:0]};
        sh = $signed({2'b00, ((e != 8'd0) ? e : 8'd1)}) - 10'sd119;
        rsh = 10'(-sh);
        mag = 32'd0;
        if (sh >= 0) begin
            mag = {8'd0, m} << sh[2:0];
        end else if (rsh < 10'd32) begin
            mag = {8'd0, m} >> rsh[4:0];
        end
        if (e == 8'hFF) begin
            float_q31 = (u[22:0] != 23'd0) ? 32'd0 : (u[31] ? 32'h80000000 : 32'h7FFFFFFF);
        end else if (sh >= 10'sd8) begin
            float_q31 = u[31] ? 32'h80000000 : 32'h7FFFFFFF;
        end else begin
            float_q31 = u[31] ? (32'd0 - mag) : mag;
        end
    endfunction

    // Sample as gathered including the byte in hand, and its Q1.31 conversion
    always_comb begin
        gval = gather_reg;
        if (pos_reg < 13'd4) begin
            gval = gather_reg | ({24'd0, s_tdata} << {pos_reg[1:0], 3'b000});
        end
        if (fcode_reg == wsp_pkg::FMT_FLOAT && bits_reg == 16'd32) begin
            conv = float_q31(gval);
        end else if (bits_reg == 16'd16) begin
            conv = {gval[15:0], 16'd0};
        end else if (bits_reg == 16'd24) begin
            conv = {gval[23:0], 8'd0};
        end else if (bits_reg == 16'd32) begin
            conv = gval;
        end else begin
            conv = 32'd0;
        end
    end

    always_comb begin
        logic body_end;
        logic slot_last;
        phase_next = phase_reg;     cnt_next = cnt_reg;
        tag_next = tag_reg;         len_next = len_reg;
        hdr_ok_next = hdr_ok_reg;   fcode_next = fcode_reg;
        chans_next = chans_reg;     rate_next = rate_reg;
        bits_next = bits_reg;       fmt_seen_next = fmt_seen_reg;
        data_seen_next = data_seen_reg;
        gather_next = gather_reg;   pos_next = pos_reg;
        sidx_next = sidx_reg;       left_next = left_reg;
        right_next = right_reg;     frames_next = frames_reg;
        frame_we = 1'b0;
        body_end = 1'b0;
        slot_last = (pos_reg == bps - 13'd1);

        if (take && s_tuser) begin
            unique case (phase_reg)
                wsp_pkg::PH_RIFF: begin
                    if (cnt_reg < 32'd4 || cnt_reg >= 32'd8) begin
                        tag_next = {tag_reg[23:0], s_tdata};
                    end
                    cnt_next = cnt_inc;
                    if (cnt_reg == 32'd3 && tag_next != wsp_pkg::TAG_RIFF) begin
                        phase_next = wsp_pkg::PH_FAIL;
                    end else if (cnt_reg == 32'd11) begin
                        if (tag_next != wsp_pkg::TAG_WAVE) begin
                            phase_next = wsp_pkg::PH_FAIL;
                        end else begin
                            hdr_ok_next = 1'b1;
                            phase_next = wsp_pkg::PH_CHUNK;
                            cnt_next = 32'd0;
                        end
                    end
                end
                wsp_pkg::PH_CHUNK: begin
                    if (cnt_reg < 32'd4) begin
                        tag_next = {tag_reg[23:0], s_tdata};
                    end else begin
                        case (cnt_reg[1:0])
                            2'd0: len_next[7:0] = s_tdata;
                            2'd1: len_next[15:8] = s_tdata;
                            2'd2: len_next[23:16] = s_tdata;
                            default: len_next[31:24] = s_tdata;
                        endcase
                    end
                    cnt_next = cnt_inc;
                    if (cnt_reg == 32'd7) begin
                        cnt_next = 32'd0;
                        if (tag_next == wsp_pkg::TAG_FMT) begin
                            fmt_seen_next = 1'b1;
                            phase_next = wsp_pkg::PH_FMT;
                        end else if (tag_next == wsp_pkg::TAG_DATA) begin
                            phase_next = wsp_pkg::PH_DATA;
                            pos_next = 13'd0;
                            sidx_next = 16'd0;
                            gather_next = 32'd0;
                        end else begin
                            phase_next = wsp_pkg::PH_SKIP;
                        end
                        body_end = (len_next == 32'd0);
                    end
                end
                wsp_pkg::PH_FMT: begin
                    case (cnt_reg)
                        32'd0:  fcode_next[7:0] = s_tdata;
                        32'd1:  fcode_next[15:8] = s_tdata;
                        32'd2:  chans_next[7:0] = s_tdata;
                        32'd3:  chans_next[15:8] = s_tdata;
                        32'd4:  rate_next[7:0] = s_tdata;
                        32'd5:  rate_next[15:8] = s_tdata;
                        32'd6:  rate_next[23:16] = s_tdata;
                        32'd7:  rate_next[31:24] = s_tdata;
                        32'd14: bits_next[7:0] = s_tdata;
                        32'd15: bits_next[15:8] = s_tdata;
                        default: ;
                    endcase
                    cnt_next = cnt_inc;
                    body_end = (cnt_inc == len_reg);
                end
                wsp_pkg::PH_DATA: begin
                    data_seen_next = data_seen_reg + 32'd1;
                    if (fmt_seen_reg && bps != 13'd0) begin
                        // gather while in the first two channels of the frame
                        if (sidx_reg < 16'd2) begin
                            gather_next = gval;
                            if (slot_last) begin
                                gather_next = 32'd0;
                                if (sidx_reg == 16'd0) left_next = conv;
                                else right_next = conv;
                            end
                        end
                        if (slot_last) begin
                            pos_next = 13'd0;
                            if (sidx_reg == ch_eff - 16'd1) begin
                                sidx_next = 16'd0;
                                frame_we = 1'b1;
                                frames_next = frames_reg + 32'd1;
                            end else begin
                                sidx_next = sidx_reg + 16'd1;
                            end
                        end else begin
                            pos_next = pos_reg + 13'd1;
                        end
                    end
                    cnt_next = cnt_inc;
                    body_end = (cnt_inc == len_reg);
                end
                wsp_pkg::PH_SKIP: begin
                    cnt_next = cnt_inc;
                    body_end = (cnt_inc == len_reg);
                end
                wsp_pkg::PH_PAD: begin
                    phase_next = wsp_pkg::PH_CHUNK;
                    cnt_next = 32'd0;
                end
                default: ;
            endcase
            if (body_end) begin
                phase_next = len_next[0] ? wsp_pkg::PH_PAD : wsp_pkg::PH_CHUNK;
                cnt_next = 32'd0;
            end
        end

        frame_res = '0;
        frame_res.left_sample = left_next;
        frame_res.right_sample = (chans_reg >= 16'd2) ? right_next : left_next;

        status_we = take && s_tlast;
        status_res = '0;
        status_res.kind = 1'b1;
        if (!hdr_ok_next) status_res.status = wsp_pkg::ST_BAD_HDR;
        else if (!fmt_seen_next) status_res.status = wsp_pkg::ST_NO_FMT;
        else if (data_seen_next == 32'd0) status_res.status = wsp_pkg::ST_NO_DATA;
        else if (bits_next[15:3] == 13'd0) status_res.status = wsp_pkg::ST_BAD_DEPTH;
        else status_res.status = wsp_pkg::ST_OK;
        status_res.sample_rate = rate_next;
        status_res.channel_count = chans_next;
        status_res.frame_count = frames_next;
    end

    // Parse state; end of file clears everything for the next file
    always_ff @(posedge aclk) begin
        if (!aresetn || status_we) begin
            phase_reg <= wsp_pkg::PH_RIFF;  cnt_reg <= '0;
            tag_reg <= '0;                  len_reg <= '0;
            hdr_ok_reg <= 1'b0;             fcode_reg <= '0;
            chans_reg <= '0;                rate_reg <= '0;
            bits_reg <= '0;                 fmt_seen_reg <= 1'b0;
            data_seen_reg <= '0;            gather_reg <= '0;
            pos_reg <= '0;                  sidx_reg <= '0;
            left_reg <= '0;                 right_reg <= '0;
            frames_reg <= '0;
        end else begin
            phase_reg <= phase_next;        cnt_reg <= cnt_next;
            tag_reg <= tag_next;            len_reg <= len_next;
            hdr_ok_reg <= hdr_ok_next;      fcode_reg <= fcode_next;
            chans_reg <= chans_next;        rate_reg <= rate_next;
            bits_reg <= bits_next;          fmt_seen_reg <= fmt_seen_next;
            data_seen_reg <= data_seen_next; gather_reg <= gather_next;
            pos_reg <= pos_next;            sidx_reg <= sidx_next;
            left_reg <= left_next;          right_reg <= right_next;
            frames_reg <= frames_next;
        end
    end

    // Result queue: frame first, then status, in consecutive entries
    logic       pop;
    logic [1:0] n_push;
    assign pop = m_tvalid && m_tready;
    assign n_push = {1'b0, frame_we} + {1'b0, status_we};

    always_ff @(posedge aclk) begin
        if (frame_we) begin
            queue_mem[wr_ptr_reg] <= frame_res;
        end
        if (status_we) begin
            queue_mem[frame_we ? wr_ptr_reg + 2'd1 : wr_ptr_reg] <= status_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + n_push;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            fill_reg <= fill_reg + {1'b0, n_push} - {2'b00, pop};
        end
    end

    wsp_pkg::result_t head;
    assign head = queue_mem[rd_ptr_reg];
    assign m_tvalid = (fill_reg != 3'd0);
    assign m_tuser = head.kind;
    assign m_tdata = {5'd0, head.frame_count, head.channel_count, head.sample_rate,
                      head.status, head.right_sample, head.left_sample};

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= 3'd4) else $error("result queue overflow");
    a_eof_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        take && s_tlast |=> phase_reg == wsp_pkg::PH_RIFF && frames_reg == 32'd0)
        else $error("parser not cleared after end of file");
    a_fail_no_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == wsp_pkg::PH_FAIL |-> !hdr_ok_reg)
        else $error("failed header phase with header marked good");
    a_frame_needs_fmt: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_we |-> fmt_seen_reg && bps != 13'd0)
        else $error("frame emitted without a usable format");
`endif

endmodule

@@ verif/tb.sv @@
// Testbench for wav_stream_parser_top: drives generated WAV files byte by byte,
// predicts frames and status items, and checks every result item. Depends on wsp_pkg.
`timescale 1ns / 1ps

typedef struct {
    logic        kind;
    logic [31:0] left_sample;
    logic [31:0] right_sample;
    logic [2:0]  status;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [31:0] frame_count;
} wav_result_t;

// Parser prediction and the queue of expected result items.
class wav_scoreboard;
    logic [2:0]  phase;
    logic [31:0] cnt, tag, clen, fmt_code, chans, rate, bits, seen_data;
    logic [31:0] gather, foff, hleft, hright, frames;
    logic        pad, hdr_ok, fmt_seen;
    logic [7:0]  b_cur;
    wav_result_t pending_q[$];
    int          errors;

    function new();
        errors = 0;
        clear();
    endfunction

    function void clear();
        phase = wsp_pkg::PH_RIFF; cnt = 0; tag = 0; clen = 0; pad = 1'b0; hdr_ok = 1'b0;
        fmt_code = 0; chans = 0; rate = 0; bits = 0; fmt_seen = 1'b0;
        seen_data = 0; gather = 0; foff = 0; hleft = 0; hright = 0; frames = 0;
    endfunction

    function logic [31:0] float_q31(logic [31:0] u);
        logic [31:0] m, mag;
        int          sh;
        if (u[30:23] == 8'hFF) begin
            if (u[22:0] != 0) return 0;
            return u[31] ? 32'h80000000 : 32'h7FFFFFFF;
        end
        m = (u[30:23] != 0) ? {9'd1, u[22:0]} : {9'd0, u[22:0]};
        sh = ((u[30:23] != 0) ? int'(u[30:23]) : 1) - 119;
        if (sh >= 8) return u[31] ? 32'h80000000 : 32'h7FFFFFFF;
        if (sh >= 0) mag = m << sh;
        else if (-sh < 32) mag = m >> (-sh);
        else mag = 0;
        return u[31] ? (32'd0 - mag) : mag;
    endfunction

    function logic [31:0] to_q31(logic [31:0] g);
        if (fmt_code[15:0] == wsp_pkg::FMT_FLOAT && bits == 32) return float_q31(g);
        if (bits == 16) return {g[15:0], 16'd0};
        if (bits == 24) return {g[23:0], 8'd0};
        if (bits == 32) return g;
        return 0;
    endfunction

    function void close_body();
        pad = clen[0];
        phase = pad ? wsp_pkg::PH_PAD : wsp_pkg::PH_CHUNK;
        cnt = 0;
    endfunction

    function void push_frame();
        wav_result_t r;
        logic [31:0] bps, ch, sidx, pos;
        bps = bits >> 3;
        if (!fmt_seen || bps == 0) return;
        ch = (chans[15:0] != 0) ? chans : 1;
        sidx = foff / bps;
        pos = foff % bps;
        if (sidx < 2 && pos < 4) gather |= 32'(b_cur) << (8 * pos);
        if (sidx < 2 && pos == bps - 1) begin
            if (sidx == 0) hleft = to_q31(gather);
            else hright = to_q31(gather);
            gather = 0;
        end
        foff++;
        if (foff < bps * ch) return;
        foff = 0;
        frames++;
        r = '{1'b0, hleft, (ch >= 2) ? hright : hleft, wsp_pkg::ST_OK,
              32'd0, 16'd0, 32'd0};
        pending_q.push_back(r);
    endfunction

    function void take(logic [7:0] b);
        b_cur = b;
        case (phase)
            wsp_pkg::PH_RIFF: begin
                if (cnt < 4 || cnt >= 8) tag = {tag[23:0], b};
                if (cnt == 3 && tag != wsp_pkg::TAG_RIFF) phase = wsp_pkg::PH_FAIL;
                else if (cnt == 11) begin
                    if (tag != wsp_pkg::TAG_WAVE) phase = wsp_pkg::PH_FAIL;
                    else begin
                        hdr_ok = 1'b1; phase = wsp_pkg::PH_CHUNK; cnt = 0;
                    end
                end else cnt++;
            end
            wsp_pkg::PH_CHUNK: begin
                if (cnt < 4) tag = {tag[23:0], b};
                else clen[8*(cnt-4) +: 8] = b;
                if (cnt < 7) cnt++;
                else begin
                    cnt = 0;
                    if (tag == wsp_pkg::TAG_FMT) begin
                        fmt_seen = 1'b1; phase = wsp_pkg::PH_FMT;
                    end else if (tag == wsp_pkg::TAG_DATA) begin
                        phase = wsp_pkg::PH_DATA; foff = 0; gather = 0;
                    end else phase = wsp_pkg::PH_SKIP;
                    if (clen == 0) close_body();
                end
            end
            wsp_pkg::PH_FMT: begin
                if (cnt < 2) fmt_code[8*cnt +: 8] = b;
                else if (cnt < 4) chans[8*(cnt-2) +: 8] = b;
                else if (cnt < 8) rate[8*(cnt-4) +: 8] = b;
                else if (cnt == 14 || cnt == 15) bits[8*(cnt-14) +: 8] = b;
                cnt++;
                if (cnt == clen) close_body();
            end
            wsp_pkg::PH_DATA: begin
                seen_data++;
                push_frame();
                cnt++;
                if (cnt == clen) close_body();
            end
            wsp_pkg::PH_SKIP: begin
                cnt++;
                if (cnt == clen) close_body();
            end
            wsp_pkg::PH_PAD: begin
                pad = 1'b0; phase = wsp_pkg::PH_CHUNK; cnt = 0;
            end
            default: ;
        endcase
    endfunction

    // Note one accepted input item.
    function void note_input(logic [7:0] b, logic has_b, logic eof);
        wav_result_t r;
        logic [2:0]  st;
        if (has_b) take(b);
        if (!eof) return;
        if (!hdr_ok) st = wsp_pkg::ST_BAD_HDR;
        else if (!fmt_seen) st = wsp_pkg::ST_NO_FMT;
        else if (seen_data == 0) st = wsp_pkg::ST_NO_DATA;
        else if ((bits >> 3) == 0) st = wsp_pkg::ST_BAD_DEPTH;
        else st = wsp_pkg::ST_OK;
        r = '{1'b1, 32'd0, 32'd0, st, rate, chans[15:0], frames};
        pending_q.push_back(r);
        clear();
    endfunction

    // Check one accepted result item against the oldest expectation.
    function void check(logic kind, logic [151:0] d);
        wav_result_t e;
        if (pending_q.size() == 0) begin
            $error("unexpected result item kind=%0d", kind);
            errors++;
            return;
        end
        e = pending_q.pop_front();
        if (kind != e.kind) begin
            $error("kind exp %0d got %0d", e.kind, kind); errors++;
        end
        if (d[31:0] != e.left_sample) begin
            $error("left_sample exp %h got %h", e.left_sample, d[31:0]); errors++;
        end
        if (d[63:32] != e.right_sample) begin
            $error("right_sample exp %h got %h", e.right_sample, d[63:32]); errors++;
        end
        if (d[66:64] != e.status) begin
            $error("status exp %0d got %0d", e.status, d[66:64]); errors++;
        end
        if (d[98:67] != e.sample_rate) begin
            $error("sample_rate exp %0d got %0d", e.sample_rate, d[98:67]); errors++;
        end
        if (d[114:99] != e.channel_count) begin
            $error("channel_count exp %0d got %0d", e.channel_count, d[114:99]);
            errors++;
        end
        if (d[146:115] != e.frame_count) begin
            $error("frame_count exp %0d got %0d", e.frame_count, d[146:115]); errors++;
        end
        if (d[151:147] != 0) begin
            $error("zero fill exp 0 got %h", d[151:147]); errors++;
        end
    endfunction
endclass

module tb;
    localparam int WATCHDOG = 5000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;   // data_byte
    logic         s_tuser;   // has_byte
    logic         s_tlast;   // end_of_file
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;   // left, right, status, rate, channels, frames, zero fill
    logic         m_tuser;   // kind

    int           send_idle;     // percent of cycles the sender holds back
    int           stall_pct;     // percent of cycles the receiver stalls
    int           items_sent;
    int           quiet_cycles;
    wav_scoreboard wav_sb;
    logic [7:0]   file_q[$];

    wav_stream_parser_top DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Receiver: stall at random, check each accepted result item.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) wav_sb.check(m_tuser, m_tdata);
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: count cycles without any handshake.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("FAIL");
            $finish;
        end
    end

    // Hold one item on the bus until accepted, with random idle gaps first.
    // tvalid stays up after acceptance; the next call's idle gaps or a drain drop it.
    task automatic send_item(logic [7:0] b, logic has_b, logic eof);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= has_b;
        s_tlast <= eof;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        wav_sb.note_input(b, has_b, eof);
        items_sent++;
    endtask

    // Send the queued file; tlast goes on the final byte or on a bare marker.
    task automatic send_file(bit bare_end);
        int n;
        n = file_q.size();
        for (int i = 0; i < n; i++)
            send_item(file_q[i], 1'b1, (i == n - 1) && !bare_end);
        if (bare_end || n == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
        file_q.delete();
    endtask

    task automatic put_word(logic [31:0] w, int nbytes);
        for (int i = 0; i < nbytes; i++) file_q.push_back(w[8*i +: 8]);
    endtask

    task automatic put_tag(logic [31:0] t);
        for (int i = 3; i >= 0; i--) file_q.push_back(t[8*i +: 8]);
    endtask

    task automatic put_fmt(logic [15:0] code, logic [15:0] ch, logic [31:0] rate,
                           logic [15:0] bits, logic [31:0] len);
        put_tag(wsp_pkg::TAG_FMT); put_word(len, 4);
        put_word({16'd0, code}, 2); put_word({16'd0, ch}, 2); put_word(rate, 4);
        put_word($urandom, 4); put_word($urandom, 2); put_word({16'd0, bits}, 2);
        for (int i = 16; i < len; i++) file_q.push_back(8'($urandom_range(255)));
        if (len[0]) file_q.push_back(8'($urandom_range(255)));
    endtask

    // Data chunk with random body bytes, biased to float specials.
    task automatic put_data(logic [31:0] len);
        logic [31:0] w;
        put_tag(wsp_pkg::TAG_DATA); put_word(len, 4);
        for (int i = 0; i < len; i += 4) begin
            case ($urandom_range(7))
                0: w = 32'h7F800000 | {1'($urandom_range(1)), 31'd0};
                1: w = 32'h7FC00001;
                2: w = {1'($urandom_range(1)), 8'($urandom_range(110, 135)),
                        23'($urandom)};
                3: w = {$urandom_range(1) ? 16'h8000 : 16'h7FFF, 16'h0000};
                default: w = $urandom;
            endcase
            for (int j = 0; j < 4 && i + j < len; j++) file_q.push_back(w[8*j +: 8]);
        end
        if (len[0]) file_q.push_back(8'($urandom_range(255)));
    endtask

    task automatic put_header();
        put_tag(wsp_pkg::TAG_RIFF); put_word($urandom, 4); put_tag(wsp_pkg::TAG_WAVE);
    endtask

    // A random file with random format, sizes, extra chunks and truncation.
    task automatic random_file();
        logic [15:0] bits_sel[6] = '{16'd16, 16'd24, 16'd32, 16'd32, 16'd8, 16'd0};
        logic [15:0] bits, code, ch;
        int          k;
        k = $urandom_range(5);
        bits = bits_sel[k];
        code = (k == 3 || $urandom_range(9) == 0) ? wsp_pkg::FMT_FLOAT : 16'd1;
        ch = ($urandom_range(9) == 0) ? 16'($urandom_range(3, 5)) : 16'($urandom_range(0, 2));
        if ($urandom_range(19) == 0) ch = 16'hFFFF;
        put_header();
        if ($urandom_range(4) == 0) begin
            put_tag($urandom); put_word($urandom_range(0, 5), 4);
            for (int i = file_q.size(); file_q.size() - i < file_q[$-3]; )
                file_q.push_back(8'($urandom));
        end
        put_fmt(code, ch, $urandom, bits, ($urandom_range(7) == 0) ? $urandom_range(10, 19) : 16);
        put_data($urandom_range(0, 30));
        if ($urandom_range(3) == 0) put_data($urandom_range(1, 13));
        if ($urandom_range(5) == 0) file_q = file_q[0:$urandom_range(file_q.size() - 1)];
        send_file($urandom_range(4) == 0);
    endtask

    // Noise: random bytes, often with a broken tag, plus idle no-byte items.
    task automatic noise_file();
        if ($urandom_range(1)) put_tag(wsp_pkg::TAG_RIFF);
        repeat ($urandom_range(1, 16)) file_q.push_back(8'($urandom_range(255)));
        for (int i = 0; i < file_q.size(); i++) begin
            if ($urandom_range(3) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(file_q[i], 1'b1, i == file_q.size() - 1);
        end
        file_q.delete();
    endtask

    // Drop tvalid and hold until every expected result item has come.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (wav_sb.pending_q.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int phase_sel;
        wav_sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = 8'd0; s_tuser = 1'b0; s_tlast = 1'b0;
        m_tready = 1'b0;
        send_idle = 0; stall_pct = 0; items_sent = 0; quiet_cycles = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: bare end marker, bad RIFF tag, bad WAVE tag, no fmt.
        send_item(8'hFF, 1'b0, 1'b1);
        put_tag(32'h52494647); send_file(1'b0);
        put_tag(wsp_pkg::TAG_RIFF); put_word(0, 4); put_tag(32'h57415646); send_file(1'b0);
        put_header(); send_file(1'b0);
        // fmt only (no data), 16-bit stereo with odd-length skipped chunk.
        put_header(); put_fmt(16'd1, 16'd2, 32'd48000, 16'd16, 32'd16); send_file(1'b1);
        put_header(); put_tag(32'h4C495354); put_word(3, 4); put_word(0, 4);
        put_fmt(16'd1, 16'd2, 32'd44100, 16'd16, 32'd16); put_data(32'd9); send_file(1'b0);
        // Float extremes, mono 24-bit, 3 channels 32-bit, unsupported 8-bit depth.
        put_header(); put_fmt(wsp_pkg::FMT_FLOAT, 16'd1, 32'hFFFFFFFF, 16'd32, 32'd16);
        put_data(32'd24);
        send_file(1'b0);
        put_header(); put_fmt(16'd1, 16'd0, 32'd8000, 16'd24, 32'd16); put_data(32'd12);
        send_file(1'b0);
        put_header(); put_fmt(16'd1, 16'd3, 32'd96000, 16'd32, 32'd16); put_data(32'd24);
        send_file(1'b0);
        put_header(); put_fmt(16'd1, 16'd1, 32'd22050, 16'd8, 32'd16); put_data(32'd4);
        send_file(1'b0);

        // Pause until every expected result has come.
        wait_drained();

        while (items_sent < 800) begin
            phase_sel = (items_sent / 100) % 4;
            send_idle = (phase_sel == 1 || phase_sel == 3) ? ((phase_sel == 3) ? 22 : 65) : 0;
            stall_pct = (phase_sel == 2 || phase_sel == 3) ? ((phase_sel == 3) ? 22 : 65) : 0;
            if ($urandom_range(7) == 0) noise_file();
            else random_file();
        end
        wait_drained();
        repeat (20) @(posedge aclk);
        if (wav_sb.errors == 0 && wav_sb.pending_q.size() == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule
